[src/vrs_pkg.sv]
// vrs_pkg: shared types, codes and helpers of the vector autoregression block
// used by vrs_store, vrs_mac_unit and var_recursive_simulator_top
`default_nettype none

package vrs_pkg;

    // default sizes handed to the top level
    localparam int CHANNELS_DEF = 4;
    localparam int MAX_LAGS_DEF = 4;

    // input item kinds, carried in tuser
    typedef enum logic [1:0] {
        CMD_LOAD_COEF = 2'd0,
        CMD_LOAD_ICPT = 2'd1,
        CMD_SEED      = 2'd2,
        CMD_STEP      = 2'd3
    } cmd_t;

    // configuration register indexes
    localparam logic [1:0] CFG_LAGS_IN_USE   = 2'd0;
    localparam logic [1:0] CFG_USE_INTERCEPT = 2'd1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_MAC,
        ST_DRAIN,
        ST_FINISH,
        ST_WRITE,
        ST_EMIT
    } state_t;

    // store controls from the sequencer
    typedef struct packed {
        logic coef_we;
        logic hist_we;
        logic rd_en;
    } store_ctrl_t;

    // multiply-accumulate controls from the sequencer
    typedef struct packed {
        logic init;
        logic issue;
    } mac_ctrl_t;

    // multiply-accumulate status back to the sequencer
    typedef struct packed {
        logic busy;
    } mac_stat_t;

    // address width of a store, at least one bit
    function automatic int addr_w(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

`default_nettype wire

[src/vrs_store.sv]
// vrs_store: coefficient memory and lag history memory, read data registered
// depends on vrs_pkg
`default_nettype none

module vrs_store #(
    parameter int CHANNELS = vrs_pkg::CHANNELS_DEF,
    parameter int MAX_LAGS = vrs_pkg::MAX_LAGS_DEF
) (
    input  wire                                                   clk,
    input  vrs_pkg::store_ctrl_t                                  ctrl,
    input  wire [vrs_pkg::addr_w(CHANNELS*CHANNELS*MAX_LAGS)-1:0] coef_waddr,
    input  wire [vrs_pkg::addr_w(CHANNELS*CHANNELS*MAX_LAGS)-1:0] coef_raddr,
    input  wire signed [31:0]                                     coef_wdata,
    input  wire [vrs_pkg::addr_w(CHANNELS*MAX_LAGS)-1:0]          hist_waddr,
    input  wire [vrs_pkg::addr_w(CHANNELS*MAX_LAGS)-1:0]          hist_raddr,
    input  wire signed [31:0]                                     hist_wdata,
    output logic signed [31:0]                                    coef_q,
    output logic signed [31:0]                                    hist_q
);
    import vrs_pkg::*;

    localparam int COEF_DEPTH = CHANNELS * CHANNELS * MAX_LAGS;
    localparam int HIST_DEPTH = CHANNELS * MAX_LAGS;

    logic signed [31:0] coef_mem [COEF_DEPTH];
    logic signed [31:0] hist_mem [HIST_DEPTH];

    // coefficient memory
    always_ff @(posedge clk)
    begin
        if (ctrl.coef_we)
        begin
            coef_mem[coef_waddr] <= coef_wdata;
        end
        if (ctrl.rd_en)
        begin
            coef_q <= coef_mem[coef_raddr];
        end
    end

    // lag history memory, rows rotate under a base offset kept by the sequencer
    always_ff @(posedge clk)
    begin
        if (ctrl.hist_we)
        begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        if (ctrl.rd_en)
        begin
            hist_q <= hist_mem[hist_raddr];
        end
    end

endmodule

`default_nettype wire

[src/vrs_mac_unit.sv]
// vrs_mac_unit: shared multiplier and wide accumulator with round and saturate
// depends on vrs_pkg
`default_nettype none

module vrs_mac_unit #(
    parameter int ACC_W = 74
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  vrs_pkg::mac_ctrl_t       ctrl,
    input  wire signed [ACC_W-1:0]   init_value,
    input  wire signed [31:0]        coef,
    input  wire signed [31:0]        past,
    output vrs_pkg::mac_stat_t       stat,
    output logic signed [31:0]       result
);
    import vrs_pkg::*;

    logic                    rd_v_reg;
    logic                    prod_v_reg;
    logic signed [63:0]      prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] rnd;

    // operand valid pipeline, aligned with the registered memory reads
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg   <= 1'b0;
            prod_v_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg   <= ctrl.issue;
            prod_v_reg <= rd_v_reg;
        end
    end

    // product register and accumulator
    always_ff @(posedge clk)
    begin
        if (rd_v_reg)
        begin
            prod_reg <= coef * past;
        end
        if (ctrl.init)
        begin
            acc_reg <= init_value;
        end
        else if (prod_v_reg)
        begin
            acc_reg <= acc_reg + {{(ACC_W-64){prod_reg[63]}}, prod_reg};
        end
    end

    assign stat.busy = rd_v_reg | prod_v_reg;

    // round half up, drop 16 fraction bits, saturate to 32 bits
    always_comb
    begin
        rnd = acc_reg + {{(ACC_W-16){1'b0}}, 16'h8000};
        if ((&rnd[ACC_W-1:47]) || !(|rnd[ACC_W-1:47]))
        begin
            result = rnd[47:16];
        end
        else if (rnd[ACC_W-1])
        begin
            result = 32'sh8000_0000;
        end
        else
        begin
            result = 32'sh7fff_ffff;
        end
    end

endmodule

`default_nettype wire

[src/var_recursive_simulator_top.sv]
// var_recursive_simulator_top: sequencer, small stores and stream ports of the
// vector autoregression block; depends on vrs_pkg, vrs_store, vrs_mac_unit
//
//  channel  direction  signals                                   moves
//  s_*      in         s_tvalid s_tready s_tdata s_tuser         load, seed or step item
//  m_*      out        m_tvalid m_tready m_tdata                 series vector of a step
//  cfg_*    in         cfg_valid cfg_ready cfg_index cfg_data    register write
//
// a step runs one product per cycle through the shared multiplier, and the pipeline
// drains before each channel finishes. a step holds in its last state while the
// previous result waits.
// reset clears control state only; the stores hold nothing defined until written.
`default_nettype none

module var_recursive_simulator_top #(
    parameter int CHANNELS = vrs_pkg::CHANNELS_DEF,
    parameter int MAX_LAGS = vrs_pkg::MAX_LAGS_DEF
) (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_tvalid,
    output logic         s_tready,
    // index[5:0], value[37:6], innovation_0[69:38], innovation_1[101:70],
    // innovation_2[133:102], innovation_3[165:134], zero pad[167:166]
    input  wire  [167:0] s_tdata,
    // command[1:0]
    input  wire  [1:0]   s_tuser,
    output logic         m_tvalid,
    input  wire          m_tready,
    // series_0[31:0], series_1[63:32], series_2[95:64], series_3[127:96]
    output logic [127:0] m_tdata,
    input  wire          cfg_valid,
    output logic         cfg_ready,
    input  wire  [1:0]   cfg_index,
    input  wire  [2:0]   cfg_data
);
    import vrs_pkg::*;

    localparam int COEF_DEPTH = CHANNELS * CHANNELS * MAX_LAGS;
    localparam int HIST_DEPTH = CHANNELS * MAX_LAGS;
    localparam int CA_W       = addr_w(COEF_DEPTH);
    localparam int HA_W       = addr_w(HIST_DEPTH);
    localparam int CH_W       = addr_w(CHANNELS);
    localparam int NT_W       = $clog2(HIST_DEPTH + 1);
    localparam int ORD_W      = $clog2(MAX_LAGS + 1);
    localparam int ACC_W      = 66 + NT_W;

    // state and registers
    state_t             state_reg, state_next;
    logic [2:0]         lags_reg;
    logic               use_icpt_reg;
    logic [CH_W-1:0]    d_reg;
    logic [NT_W-1:0]    tc_reg;
    logic [NT_W-1:0]    nterms_reg;
    logic [CA_W-1:0]    caddr_reg;
    logic [HA_W-1:0]    hr_reg;
    logic [HA_W-1:0]    base_off_reg;
    logic signed [31:0] icpt_reg  [CHANNELS];
    logic signed [31:0] innov_reg [4];
    logic signed [31:0] fresh_reg [CHANNELS];
    logic signed [31:0] out_reg   [4];

    // input fields
    cmd_t               cmd;
    logic [5:0]         idx;
    logic signed [31:0] value;
    logic               accept;
    logic               emit_load;
    logic               d_last;
    logic               coef_idx_ok;
    logic               hist_idx_ok;
    logic [ORD_W-1:0]   order_sat;

    // datapath nets
    store_ctrl_t         st_ctrl;
    mac_ctrl_t           mc;
    mac_stat_t           ms;
    logic [CA_W-1:0]     coef_waddr;
    logic [HA_W-1:0]     hist_waddr;
    logic signed [31:0]  hist_wdata;
    logic [HA_W:0]       seed_sum;
    logic [HA_W-1:0]     seed_addr;
    logic [HA_W-1:0]     new_off;
    logic signed [31:0]  coef_q;
    logic signed [31:0]  hist_q;
    logic signed [31:0]  mac_result;
    logic signed [31:0]  icpt_sel;
    logic signed [31:0]  innov_sel;
    logic signed [31:0]  fresh_sel;
    logic signed [32:0]  init_sum;
    logic signed [ACC_W-1:0] init_value;

    assign cmd   = cmd_t'(s_tuser);
    assign idx   = s_tdata[5:0];
    assign value = s_tdata[37:6];

    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign emit_load = (state_reg == ST_EMIT) && (!m_tvalid || m_tready);
    assign d_last    = (d_reg == CH_W'(CHANNELS - 1));

    assign coef_idx_ok = (int'(idx) < COEF_DEPTH);
    assign hist_idx_ok = (int'(idx) < HIST_DEPTH);
    assign order_sat   = (int'(lags_reg) > MAX_LAGS) ? ORD_W'(MAX_LAGS) : ORD_W'(lags_reg);

    // seed address: logical slot plus the rotating base, wrapped once
    assign seed_sum  = (HA_W+1)'(idx) + {1'b0, base_off_reg};
    assign seed_addr = (seed_sum >= (HA_W+1)'(HIST_DEPTH))
                     ? HA_W'(seed_sum - (HA_W+1)'(HIST_DEPTH)) : HA_W'(seed_sum);
    // row that takes the newest vector: one row back from the base
    assign new_off   = (base_off_reg == '0) ? HA_W'(HIST_DEPTH - CHANNELS)
                     : base_off_reg - HA_W'(CHANNELS);

    // per-channel selection from the small stores
    always_comb
    begin
        icpt_sel  = '0;
        innov_sel = '0;
        fresh_sel = '0;
        for (int j = 0; j < CHANNELS; j++)
        begin
            if (d_reg == CH_W'(j))
            begin
                icpt_sel  = icpt_reg[j];
                fresh_sel = fresh_reg[j];
            end
        end
        for (int j = 0; j < 4; j++)
        begin
            if ((j < CHANNELS) && (int'(d_reg) == j))
            begin
                innov_sel = innov_reg[j];
            end
        end
    end

    // intercept and innovation as Q32.32 starting value
    assign init_sum   = (use_icpt_reg ? {icpt_sel[31], icpt_sel} : 33'sd0)
                      + {innov_sel[31], innov_sel};
    assign init_value = {{(ACC_W-49){init_sum[32]}}, init_sum, 16'h0000};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd == CMD_STEP))
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                state_next = (nterms_reg == '0) ? ST_FINISH : ST_MAC;
            end
            ST_MAC:
            begin
                if (tc_reg == nterms_reg - NT_W'(1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!ms.busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = d_last ? ST_WRITE : ST_INIT;
            end
            ST_WRITE:
            begin
                if (d_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_tready        = (state_reg == ST_IDLE);
        st_ctrl.coef_we = accept && (cmd == CMD_LOAD_COEF) && coef_idx_ok;
        st_ctrl.hist_we = (accept && (cmd == CMD_SEED) && hist_idx_ok)
                       || (state_reg == ST_WRITE);
        st_ctrl.rd_en   = (state_reg == ST_MAC);
        mc.init         = (state_reg == ST_INIT);
        mc.issue        = (state_reg == ST_MAC);
        coef_waddr      = CA_W'(idx);
        if (state_reg == ST_WRITE)
        begin
            hist_waddr = new_off + HA_W'(d_reg);
            hist_wdata = fresh_sel;
        end
        else
        begin
            hist_waddr = seed_addr;
            hist_wdata = value;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            lags_reg     <= 3'd1;
            use_icpt_reg <= 1'b1;
            base_off_reg <= '0;
            m_tvalid     <= 1'b0;
            d_reg        <= '0;
            tc_reg       <= '0;
            nterms_reg   <= '0;
            caddr_reg    <= '0;
            hr_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;

            // register writes
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_LAGS_IN_USE:   lags_reg     <= cfg_data;
                    CFG_USE_INTERCEPT: use_icpt_reg <= cfg_data[0];
                    default:           ;
                endcase
            end

            // output register hand-off
            if (emit_load)
            begin
                m_tvalid <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (cmd == CMD_STEP))
                    begin
                        d_reg      <= '0;
                        nterms_reg <= NT_W'(int'(order_sat) * CHANNELS);
                    end
                end
                ST_INIT:
                begin
                    tc_reg    <= '0;
                    caddr_reg <= CA_W'(d_reg);
                    hr_reg    <= base_off_reg;
                end
                ST_MAC:
                begin
                    tc_reg    <= tc_reg + NT_W'(1);
                    caddr_reg <= caddr_reg + CA_W'(CHANNELS);
                    hr_reg    <= (hr_reg == HA_W'(HIST_DEPTH - 1)) ? '0 : hr_reg + HA_W'(1);
                end
                ST_FINISH:
                begin
                    d_reg <= d_last ? '0 : d_reg + CH_W'(1);
                end
                ST_WRITE:
                begin
                    if (d_last)
                    begin
                        d_reg        <= '0;
                        base_off_reg <= new_off;
                    end
                    else
                    begin
                        d_reg <= d_reg + CH_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept && (cmd == CMD_LOAD_ICPT))
        begin
            for (int j = 0; j < CHANNELS; j++)
            begin
                if (int'(idx) == j)
                begin
                    icpt_reg[j] <= value;
                end
            end
        end
        if (accept && (cmd == CMD_STEP))
        begin
            innov_reg[0] <= s_tdata[69:38];
            innov_reg[1] <= s_tdata[101:70];
            innov_reg[2] <= s_tdata[133:102];
            innov_reg[3] <= s_tdata[165:134];
        end
        if (state_reg == ST_FINISH)
        begin
            for (int j = 0; j < CHANNELS; j++)
            begin
                if (d_reg == CH_W'(j))
                begin
                    fresh_reg[j] <= mac_result;
                end
            end
        end
        if (emit_load)
        begin
            for (int j = 0; j < 4; j++)
            begin
                out_reg[j] <= (j < CHANNELS) ? fresh_reg[j] : 32'sd0;
            end
        end
    end

    assign m_tdata = {out_reg[3], out_reg[2], out_reg[1], out_reg[0]};

    // stores
    vrs_store #(
        .CHANNELS (CHANNELS),
        .MAX_LAGS (MAX_LAGS)
    ) u_store (
        .clk        (clk),
        .ctrl       (st_ctrl),
        .coef_waddr (coef_waddr),
        .coef_raddr (caddr_reg),
        .coef_wdata (value),
        .hist_waddr (hist_waddr),
        .hist_raddr (hr_reg),
        .hist_wdata (hist_wdata),
        .coef_q     (coef_q),
        .hist_q     (hist_q)
    );

    // shared multiply-accumulate unit
    vrs_mac_unit #(
        .ACC_W (ACC_W)
    ) u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (mc),
        .init_value (init_value),
        .coef       (coef_q),
        .past       (hist_q),
        .stat       (ms),
        .result     (mac_result)
    );

    // checks
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !ms.busy)
        else $error("multiplier pipeline busy while taking input");

    a_emit_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_EMIT))
        else $error("result raised outside the emit state");

    a_base_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MAC) |-> ((int'(base_off_reg) < HIST_DEPTH)
                               && (int'(hr_reg) < HIST_DEPTH)))
        else $error("history pointer out of range");

endmodule

`default_nettype wire
